// ===== rtl/stq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Timer queue package
// Shared widths, command and result codes, and the slot record type.
// ----------------------------------------------------------------------------
package stq_pkg;

   localparam int TIMER_SLOTS     = 16;
   localparam int SLOT_BITS       = 4;
   localparam int TIME_BITS       = 48;
   localparam int PERIOD_BITS     = 32;
   localparam int GENERATION_BITS = 8;
   localparam int COUNT_BITS      = 5;

   localparam logic [1:0] CMD_CREATE = 2'd0;
   localparam logic [1:0] CMD_CANCEL = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;
   localparam logic [1:0] CMD_TICK   = 2'd3;

   localparam logic [2:0] KIND_CREATED = 3'd0;
   localparam logic [2:0] KIND_CANCEL  = 3'd1;
   localparam logic [2:0] KIND_CLEARED = 3'd2;
   localparam logic [2:0] KIND_FIRED   = 3'd3;
   localparam logic [2:0] KIND_NONE    = 3'd4;

   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   typedef struct packed {
      logic [TIME_BITS-1:0]   fire_time;
      logic [PERIOD_BITS-1:0] period;
   } slot_rec_type;

   typedef struct packed {
      logic [2:0]                 kind;
      logic                       ok;
      logic [SLOT_BITS-1:0]       slot;
      logic [GENERATION_BITS-1:0] generation;
      logic [COUNT_BITS-1:0]      count;
      logic                       last;
   } result_type;

   function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] t,
                                                    input logic [PERIOD_BITS-1:0] d);
      logic [TIME_BITS:0] s;
      s = {1'b0, t} + {{(TIME_BITS + 1 - PERIOD_BITS){1'b0}}, d};
      return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/stq_slot_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slot record memory
// Fire time and period per slot; one write port, one registered read port.
// ----------------------------------------------------------------------------
module stq_slot_ram (
   input  wire                                    clock,
   input  wire                                    wr_en,
   input  wire        [stq_pkg::SLOT_BITS-1:0]    wr_addr,
   input  wire        stq_pkg::slot_rec_type      wr_data,
   input  wire        [stq_pkg::SLOT_BITS-1:0]    rd_addr,
   output stq_pkg::slot_rec_type                  rd_data
);

   stq_pkg::slot_rec_type mem [stq_pkg::TIMER_SLOTS];
   stq_pkg::slot_rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/software_timer_queue_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Software timer queue unit
// Sixteen one-shot or periodic timer slots driven by create, cancel, clear
// and tick requests.
// ----------------------------------------------------------------------------
// Create, cancel and clear give their result in the cycle after the request is
// taken; the next request is taken once that result is accepted.
// A tick runs repeated passes over the slot memory (one read per slot), each
// firing the earliest due timer, until none is due or all sixteen have fired;
// the last result carries the fired count and can be held by output stalls.
// Reset clears the active and periodic flags and the generation counters at once; no sweep.
// ----------------------------------------------------------------------------
module software_timer_queue_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // command[1:0], now[49:2], duration[81:50], recurring[82],
   // cancel_slot[86:83], cancel_generation[94:87], zero fill [95]
   input  wire  [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // result_kind[2:0], ok[3], slot[7:4], generation[15:8],
   // processed_count[20:16], zero fill [23:21]
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast
);

   localparam int SB = stq_pkg::SLOT_BITS;
   localparam int GB = stq_pkg::GENERATION_BITS;
   localparam int N  = stq_pkg::TIMER_SLOTS;
   localparam int COUNT_BITS_L = stq_pkg::COUNT_BITS;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_PICK  = 3'd2;
   localparam logic [2:0] ST_FIRE  = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;
   localparam logic [2:0] ST_READ  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [N-1:0] active_ff, active_in, periodic_ff, periodic_in, fired_ff, fired_in;
   logic [GB-1:0] gen_ff [N];
   logic [GB-1:0] gen_in [N];

   logic [stq_pkg::TIME_BITS-1:0] now_ff;

   // scan: address issued, address of data arriving
   logic [SB:0] scan_ff, scan_in;
   logic rd_ok_ff, rd_ok_in;
   logic [SB-1:0] rd_idx_ff, rd_idx_in;
   logic best_v_ff, best_v_in;
   logic [SB-1:0] best_ff, best_in;
   logic [stq_pkg::TIME_BITS-1:0] best_t_ff, best_t_in;
   logic [COUNT_BITS_L-1:0] n_ff, n_in;

   stq_pkg::result_type res_ff, res_in;
   stq_pkg::result_type pend_ff, pend_in;
   logic rsp_v_ff, rsp_v_in;

   logic wr_en;
   logic [SB-1:0] wr_addr, rd_addr;
   stq_pkg::slot_rec_type wr_data, rd_data;

   stq_slot_ram u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   logic [SB-1:0] free_idx;
   logic free_v;
   always_comb begin
      free_idx = '0;
      free_v = 1'b0;
      for (int i = N - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_idx = SB'(i);
            free_v = 1'b1;
         end
      end
   end

   assign req_tready = (state_ff == ST_IDLE) && !rsp_v_ff;
   wire accept = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      active_in = active_ff;
      periodic_in = periodic_ff;
      fired_in = fired_ff;
      gen_in = gen_ff;
      scan_in = scan_ff;
      rd_ok_in = 1'b0;
      rd_idx_in = scan_ff[SB-1:0];
      best_v_in = best_v_ff;
      best_in = best_ff;
      best_t_in = best_t_ff;
      n_in = n_ff;
      res_in = res_ff;
      pend_in = pend_ff;
      rsp_v_in = rsp_v_ff;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      rd_addr = scan_ff[SB-1:0];
      if (rsp_v_ff && rsp_tready) begin
         rsp_v_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_in = '0;
               res_in.last = 1'b1;
               unique case (req_tdata[1:0])
                  stq_pkg::CMD_CREATE: begin
                     res_in.kind = stq_pkg::KIND_CREATED;
                     if (free_v) begin
                        gen_in[free_idx] = gen_ff[free_idx] + GB'(1);
                        active_in[free_idx] = 1'b1;
                        periodic_in[free_idx] = req_tdata[82];
                        wr_en = 1'b1;
                        wr_addr = free_idx;
                        wr_data.period = (req_tdata[81:50] == '0) ? 32'd1 : req_tdata[81:50];
                        wr_data.fire_time = stq_pkg::sat_add(req_tdata[49:2], wr_data.period);
                        res_in.ok = 1'b1;
                        res_in.slot = free_idx;
                        res_in.generation = gen_ff[free_idx] + GB'(1);
                     end
                     rsp_v_in = 1'b1;
                  end
                  stq_pkg::CMD_CANCEL: begin
                     res_in.kind = stq_pkg::KIND_CANCEL;
                     if (active_ff[req_tdata[86:83]] &&
                         gen_ff[req_tdata[86:83]] == req_tdata[94:87]) begin
                        active_in[req_tdata[86:83]] = 1'b0;
                        res_in.ok = 1'b1;
                     end
                     rsp_v_in = 1'b1;
                  end
                  stq_pkg::CMD_CLEAR: begin
                     res_in.kind = stq_pkg::KIND_CLEARED;
                     active_in = '0;
                     rsp_v_in = 1'b1;
                  end
                  stq_pkg::CMD_TICK: begin
                     fired_in = '0;
                     n_in = '0;
                     scan_in = '0;
                     best_v_in = 1'b0;
                     state_in = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            // Issue one read per cycle; compare the data returned for the prior address.
            if (!scan_ff[SB]) begin
               rd_ok_in = 1'b1;
               scan_in = scan_ff + (SB + 1)'(1);
            end
            if (rd_ok_ff && active_ff[rd_idx_ff] && !fired_ff[rd_idx_ff] &&
                rd_data.fire_time <= now_ff &&
                (!best_v_ff || rd_data.fire_time < best_t_ff)) begin
               best_v_in = 1'b1;
               best_in = rd_idx_ff;
               best_t_in = rd_data.fire_time;
            end
            if (scan_ff[SB] && !rd_ok_ff) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            if (!best_v_ff) begin
               state_in = ST_OUT;
            end else begin
               rd_addr = best_ff;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            rd_addr = best_ff;
            state_in = ST_FIRE;
         end
         ST_FIRE: begin
            // A fired result is held back until the next pass shows whether it is last.
            rd_addr = best_ff;
            if (!rsp_v_ff || rsp_tready) begin
               if (n_ff != '0) begin
                  res_in = pend_ff;
                  rsp_v_in = 1'b1;
               end
               pend_in = '0;
               pend_in.kind = stq_pkg::KIND_FIRED;
               pend_in.slot = best_ff;
               pend_in.generation = gen_ff[best_ff];
               fired_in[best_ff] = 1'b1;
               if (periodic_ff[best_ff]) begin
                  wr_en = 1'b1;
                  wr_addr = best_ff;
                  wr_data.period = rd_data.period;
                  wr_data.fire_time = stq_pkg::sat_add(now_ff, rd_data.period);
               end else begin
                  active_in[best_ff] = 1'b0;
               end
               n_in = n_ff + COUNT_BITS_L'(1);
               best_v_in = 1'b0;
               scan_in = '0;
               state_in = (n_ff == COUNT_BITS_L'(N - 1)) ? ST_PICK : ST_SCAN;
            end
         end
         ST_OUT: begin
            if (!rsp_v_ff || rsp_tready) begin
               res_in = '0;
               res_in.kind = stq_pkg::KIND_NONE;
               if (n_ff != '0) begin
                  res_in = pend_ff;
                  res_in.count = n_ff;
               end
               res_in.last = 1'b1;
               rsp_v_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         active_ff <= '0;
         periodic_ff <= '0;
         rsp_v_ff <= 1'b0;
         rd_ok_ff <= 1'b0;
         for (int i = 0; i < N; i++) begin
            gen_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         active_ff <= active_in;
         periodic_ff <= periodic_in;
         rsp_v_ff <= rsp_v_in;
         rd_ok_ff <= rd_ok_in;
         gen_ff <= gen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         now_ff <= req_tdata[49:2];
      end
      fired_ff <= fired_in;
      scan_ff <= scan_in;
      rd_idx_ff <= rd_idx_in;
      best_v_ff <= best_v_in;
      best_ff <= best_in;
      best_t_ff <= best_t_in;
      n_ff <= n_in;
      res_ff <= res_in;
      pend_ff <= pend_in;
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tlast = res_ff.last;
   assign rsp_tdata = {3'b000, res_ff.count, res_ff.generation, res_ff.slot,
                       res_ff.ok, res_ff.kind};

endmodule
`default_nettype wire
